/* src/sse_pkg.sv */
// ----------------------------------------------------------------------------
// sse_pkg
// Shared widths, command codes and the controller/datapath interface types
// of the sparse set engine.
// ----------------------------------------------------------------------------
package sse_pkg;

   // default size of the value universe
   localparam int UNIVERSE  = 64;

   // fixed field widths
   localparam int CMD_W     = 2;
   localparam int VALUE_W   = 6;
   localparam int RAND_W    = 16;
   localparam int COUNT_W   = 7;

   // modulo unit retires two quotient bits per cycle
   localparam int DIV_STEPS = RAND_W / 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_PICK   = 2'd3
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_wr;       // clearing pass: zero one entry of both stores
      logic accept;         // take the request transaction
      logic slot_rd;        // read member list at the looked-up slot
      logic found_capture;  // register the membership result
      logic ins_write;      // append value at the end of the member list
      logic last_rd;        // read the last member
      logic rem_write;      // move last member into the freed slot
      logic pick_rd;        // read member list at the remainder
      logic pick_capture;   // register the picked member
      logic rsp_load;       // load the response register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic    clear_last;
      cmd_type op;
      logic    found;
      logic    can_insert;
      logic    count_zero;
      logic    div_done;
      logic    rsp_free;
   } dp_status_type;

endpackage

/* src/sse_modulo.sv */
// ----------------------------------------------------------------------------
// sse_modulo
// Restoring remainder unit: random word modulo the member count, two
// bits per cycle.
// ----------------------------------------------------------------------------
module sse_modulo #(
   parameter int DIVISOR_W = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sse_pkg::RAND_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   output logic                         done,
   output logic [DIVISOR_W-1:0]         remainder
);

   localparam int RW    = sse_pkg::RAND_W;
   localparam int STEPS = sse_pkg::DIV_STEPS;
   localparam int SW    = $clog2(STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SW-1:0]        step_ff, step_in;
   logic [RW-1:0]        dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;

   logic [DIVISOR_W:0]   part1, part2;
   logic [DIVISOR_W-1:0] rem1, rem2;

   // two dependent compare-subtract steps
   always_comb begin
      part1 = {rem_ff, dvd_ff[RW-1]};
      if (part1 >= {1'b0, dsr_ff}) begin
         rem1 = DIVISOR_W'(part1 - {1'b0, dsr_ff});
      end else begin
         rem1 = DIVISOR_W'(part1);
      end
      part2 = {rem1, dvd_ff[RW-2]};
      if (part2 >= {1'b0, dsr_ff}) begin
         rem2 = DIVISOR_W'(part2 - {1'b0, dsr_ff});
      end else begin
         rem2 = DIVISOR_W'(part2);
      end
   end

   // iteration control; a new start always restarts the unit
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem2;
         dvd_in  = {dvd_ff[RW-3:0], 2'b00};
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   // busy and done are exclusive
   a_busy_not_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("modulo unit busy and done together");

   // a start always launches an iteration run
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && !done_ff))
      else $error("modulo unit did not start");

endmodule

/* src/sse_datapath.sv */
// ----------------------------------------------------------------------------
// sse_datapath
// Slot and member stores, member count, modulo unit and response register.
// ----------------------------------------------------------------------------
module sse_datapath #(
   parameter int UNIVERSE = sse_pkg::UNIVERSE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sse_pkg::dp_cmd_type           cmd,
   output sse_pkg::dp_status_type        status,
   input  logic [sse_pkg::CMD_W-1:0]     req_cmd,
   input  logic [sse_pkg::VALUE_W-1:0]   req_value,
   input  logic [sse_pkg::RAND_W-1:0]    req_random_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [sse_pkg::VALUE_W-1:0]   rsp_element,
   output logic                          rsp_element_valid,
   output logic [sse_pkg::COUNT_W-1:0]   rsp_count
);

   localparam int          AW      = $clog2(UNIVERSE);
   localparam int          CW      = $clog2(UNIVERSE + 1);
   localparam int          VW      = sse_pkg::VALUE_W;
   localparam int          COUNT_W = sse_pkg::COUNT_W;
   localparam logic [31:0] UNIV_U  = 32'(UNIVERSE);

   // stores
   logic [AW-1:0] sov_mem [UNIVERSE];
   logic [VW-1:0] ml_mem  [UNIVERSE];

   // control registers
   logic [AW-1:0]    clr_ff, clr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // transaction registers
   sse_pkg::cmd_type op_ff;
   logic [VW-1:0]    value_ff;
   logic             in_range_ff;
   logic             found_ff, found_in;
   logic [VW-1:0]    elem_ff, elem_in;
   logic             elem_valid_ff, elem_valid_in;
   logic [AW-1:0]    sov_rd_ff;
   logic [VW-1:0]    ml_rd_ff;

   // response register
   logic             rsp_found_ff;
   logic [VW-1:0]    rsp_element_ff;
   logic             rsp_element_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic             in_range_req;
   logic [AW-1:0]    sov_rd_addr;
   logic             sov_we;
   logic [AW-1:0]    sov_wr_addr, sov_wr_data;
   logic             ml_re, ml_we;
   logic [AW-1:0]    ml_rd_addr, ml_wr_addr;
   logic [VW-1:0]    ml_wr_data;
   logic             found_now;
   logic             div_done;
   logic [CW-1:0]    div_rem;

   // remainder of the random word by the current count
   sse_modulo #(
      .DIVISOR_W (CW)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.accept),
      .dividend  (req_random_word),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // slot store port selection
   always_comb begin
      in_range_req = 32'(req_value) < UNIV_U;
      sov_rd_addr  = in_range_req ? AW'(req_value) : '0;
      sov_we       = cmd.clear_wr | cmd.ins_write | cmd.rem_write;
      if (cmd.clear_wr) begin
         sov_wr_addr = clr_ff;
         sov_wr_data = '0;
      end else if (cmd.ins_write) begin
         sov_wr_addr = AW'(value_ff);
         sov_wr_data = AW'(count_ff);
      end else begin
         sov_wr_addr = AW'(ml_rd_ff);
         sov_wr_data = sov_rd_ff;
      end
   end

   // member store port selection
   always_comb begin
      ml_re = cmd.slot_rd | cmd.last_rd | cmd.pick_rd;
      if (cmd.slot_rd) begin
         ml_rd_addr = sov_rd_ff;
      end else if (cmd.last_rd) begin
         ml_rd_addr = AW'(count_ff - CW'(1));
      end else begin
         ml_rd_addr = AW'(div_rem);
      end
      ml_we = cmd.clear_wr | cmd.ins_write | cmd.rem_write;
      if (cmd.clear_wr) begin
         ml_wr_addr = clr_ff;
         ml_wr_data = '0;
      end else if (cmd.ins_write) begin
         ml_wr_addr = AW'(count_ff);
         ml_wr_data = value_ff;
      end else begin
         ml_wr_addr = sov_rd_ff;
         ml_wr_data = ml_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sov_we) begin
         sov_mem[sov_wr_addr] <= sov_wr_data;
      end
      if (cmd.accept) begin
         sov_rd_ff <= sov_mem[sov_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ml_we) begin
         ml_mem[ml_wr_addr] <= ml_wr_data;
      end
      if (ml_re) begin
         ml_rd_ff <= ml_mem[ml_rd_addr];
      end
   end

   // membership test: value in range, slot below count and the member there matches
   assign found_now = in_range_ff && (CW'(sov_rd_ff) < count_ff) && (ml_rd_ff == value_ff);

   // next values of counters and transaction results
   always_comb begin
      clr_in        = cmd.clear_wr ? clr_ff + AW'(1) : clr_ff;
      count_in      = count_ff;
      if (cmd.ins_write) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.rem_write) begin
         count_in = count_ff - CW'(1);
      end
      found_in      = cmd.found_capture ? found_now : found_ff;
      elem_in       = elem_ff;
      elem_valid_in = elem_valid_ff;
      if (cmd.accept) begin
         elem_in       = '0;
         elem_valid_in = 1'b0;
      end else if (cmd.pick_capture) begin
         elem_in       = ml_rd_ff;
         elem_valid_in = 1'b1;
      end
      rsp_valid_in  = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= sse_pkg::cmd_type'(req_cmd);
         value_ff    <= req_value;
         in_range_ff <= in_range_req;
      end
      found_ff      <= found_in;
      elem_ff       <= elem_in;
      elem_valid_ff <= elem_valid_in;
      if (cmd.rsp_load) begin
         rsp_found_ff         <= found_ff;
         rsp_element_ff       <= elem_ff;
         rsp_element_valid_ff <= elem_valid_ff;
         rsp_count_ff         <= COUNT_W'(count_ff);
      end
   end

   // status back to the controller
   always_comb begin
      status.clear_last = clr_ff == AW'(UNIVERSE - 1);
      status.op         = op_ff;
      status.found      = found_now;
      status.can_insert = !found_now && in_range_ff && (count_ff < CW'(UNIVERSE));
      status.count_zero = count_ff == '0;
      status.div_done   = div_done;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_valid = rsp_element_valid_ff;
   assign rsp_count         = rsp_count_ff;

   // the count never passes the universe size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(UNIVERSE))
      else $error("member count above universe");

   // a removal only ever happens after the value tested as a member
   a_remove_member: assert property (@(posedge clock) disable iff (reset)
      cmd.rem_write |-> (found_ff && count_ff != '0))
      else $error("removal of a non-member");

endmodule

/* src/sse_ctrl.sv */
// ----------------------------------------------------------------------------
// sse_ctrl
// Command sequencer: clearing pass, then per transaction the slot read,
// member read, update or division and pick read, and response load.
// ----------------------------------------------------------------------------
module sse_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output sse_pkg::dp_cmd_type     cmd,
   input  sse_pkg::dp_status_type  status
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_SLOT   = 8'b0000_0100,
      ST_MEMBER = 8'b0000_1000,
      ST_LAST   = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_PICK   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SLOT;
            end
         end
         ST_SLOT: begin
            cmd.slot_rd = 1'b1;
            state_in    = ST_MEMBER;
         end
         ST_MEMBER: begin
            cmd.found_capture = 1'b1;
            state_in          = ST_DONE;
            case (status.op)
               sse_pkg::CMD_INSERT: begin
                  cmd.ins_write = status.can_insert;
               end
               sse_pkg::CMD_REMOVE: begin
                  if (status.found) begin
                     cmd.last_rd = 1'b1;
                     state_in    = ST_LAST;
                  end
               end
               sse_pkg::CMD_PICK: begin
                  state_in = ST_DIV;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_LAST: begin
            cmd.rem_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DIV: begin
            if (status.div_done) begin
               if (status.count_zero) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.pick_rd = 1'b1;
                  state_in    = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            cmd.pick_capture = 1'b1;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   // an insert write only ever appends a value that is absent
   a_insert_absent: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_write |-> (status.op == sse_pkg::CMD_INSERT && !status.found))
      else $error("insert of a present value");

   // an accepted transaction goes straight to the slot read
   a_accept_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SLOT))
      else $error("accepted transaction did not reach slot read");

endmodule

/* src/sparse_set_engine.sv */
// ----------------------------------------------------------------------------
// sparse_set_engine
// Sparse set over the values 0 to UNIVERSE-1 with insert, remove,
// lookup and random pick.
// ----------------------------------------------------------------------------
// After reset the engine runs a clearing pass over both stores, holding
// req_stall high. It then handles one transaction at a time: each
// passes the slot read, member read and response load; removal of a
// member adds the last-member move and pick the division and pick read.
// Insert, lookup and remove are set by the two dependent reads of the
// slot store and then the member store; pick is set by the modulo unit,
// which divides the 16-bit random word by the count at two bits per
// cycle. The response sits in an output register, so the next request
// is taken while a response waits on rsp_stall.
// ----------------------------------------------------------------------------
module sparse_set_engine #(
   parameter int UNIVERSE = sse_pkg::UNIVERSE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sse_pkg::CMD_W-1:0]     req_cmd,
   input  logic [sse_pkg::VALUE_W-1:0]   req_value,
   input  logic [sse_pkg::RAND_W-1:0]    req_random_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [sse_pkg::VALUE_W-1:0]   rsp_element,
   output logic                          rsp_element_valid,
   output logic [sse_pkg::COUNT_W-1:0]   rsp_count
);

   sse_pkg::dp_cmd_type    dp_cmd;
   sse_pkg::dp_status_type dp_status;

   sse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   sse_datapath #(
      .UNIVERSE (UNIVERSE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_element       (rsp_element),
      .rsp_element_valid (rsp_element_valid),
      .rsp_count         (rsp_count)
   );

endmodule

/* bench/sparse_set_engine_tb.sv */
// ----------------------------------------------------------------------------
// sparse_set_engine_tb
// Self-checking bench for the sparse set engine. A behavioural copy of the
// set (slot store, member store and count) predicts every response as each
// request transaction is issued. Expected responses queue up in order and
// are compared field by field when the response transaction is taken. Both
// channels idle and stall at random, with stretches at full rate.
// ----------------------------------------------------------------------------
module sparse_set_engine_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_SPAN = sse_pkg::UNIVERSE;
   localparam int CMD_W    = sse_pkg::CMD_W;
   localparam int VALUE_W  = sse_pkg::VALUE_W;
   localparam int RAND_W   = sse_pkg::RAND_W;
   localparam int COUNT_W  = sse_pkg::COUNT_W;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] element;
      logic               element_valid;
      logic [COUNT_W-1:0] count;
   } set_reply_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd;
   logic [VALUE_W-1:0] req_value;
   logic [RAND_W-1:0]  req_random_word;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_found;
   logic [VALUE_W-1:0] rsp_element;
   logic               rsp_element_valid;
   logic [COUNT_W-1:0] rsp_count;

   // shadow copy of the set
   logic [VALUE_W-1:0] set_slot    [SET_SPAN];
   logic [VALUE_W-1:0] set_members [SET_SPAN];
   logic [COUNT_W-1:0] set_size;

   set_reply_type replies_due[$];

   int  mismatches    = 0;
   int  replies_seen  = 0;
   int  commands_sent = 0;
   int  op_tally[4]   = '{0, 0, 0, 0};
   int  full_hits     = 0;
   int  empty_picks   = 0;
   bit  req_no_idle   = 1'b0;
   bit  rsp_no_idle   = 1'b0;

   sparse_set_engine u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_element       (rsp_element),
      .rsp_element_valid (rsp_element_valid),
      .rsp_count         (rsp_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(5_000_000);
      $display("timeout: %0d responses still outstanding", replies_due.size());
      $display("** sparse_set_engine: FAILED **");
      $finish;
   end

   // Apply one command to the shadow set and return the response it owes
   function automatic set_reply_type predict_set_command(input sse_pkg::cmd_type op,
                                                         input logic [VALUE_W-1:0] val,
                                                         input logic [RAND_W-1:0] word);
      set_reply_type      r;
      logic               present;
      logic [VALUE_W-1:0] hole;
      logic [VALUE_W-1:0] tail;
      int                 pick_slot;
      r       = '0;
      present = (int'(val) < SET_SPAN) && ({1'b0, set_slot[val]} < set_size)
                && (set_members[set_slot[val]] == val);
      r.found = present;
      op_tally[op]++;
      case (op)
         sse_pkg::CMD_INSERT: begin
            if (!present && int'(val) < SET_SPAN && int'(set_size) < SET_SPAN) begin
               set_slot[val] = set_size[VALUE_W-1:0];
               set_members[set_size[VALUE_W-1:0]] = val;
               set_size++;
               if (int'(set_size) == SET_SPAN) full_hits++;
            end
         end
         sse_pkg::CMD_REMOVE: begin
            // last member fills the hole left by the removed one
            if (present) begin
               hole = set_slot[val];
               tail = set_members[VALUE_W'(set_size - 7'd1)];
               set_members[hole] = tail;
               set_slot[tail] = hole;
               set_size--;
            end
         end
         sse_pkg::CMD_PICK: begin
            if (set_size != '0) begin
               pick_slot       = int'(word) % int'(set_size);
               r.element       = set_members[VALUE_W'(pick_slot)];
               r.element_valid = 1'b1;
            end else begin
               empty_picks++;
            end
         end
         default: ;
      endcase
      r.count = set_size;
      return r;
   endfunction

   // Issue one request transaction after a random idle gap; returns at the
   // edge where it is accepted
   task automatic send_command(input sse_pkg::cmd_type op,
                               input logic [VALUE_W-1:0] val,
                               input logic [RAND_W-1:0] word);
      int gap;
      gap = req_no_idle ? 0 : int'($urandom_range(0, 14));
      if (gap > 0) begin
         req_valid       <= 1'b0;
         req_cmd         <= CMD_W'($urandom_range(0, 3));
         req_value       <= VALUE_W'($urandom_range(0, 63));
         req_random_word <= RAND_W'($urandom_range(0, 65535));
         repeat (gap) @(posedge clock);
      end
      replies_due.push_back(predict_set_command(op, val, word));
      req_valid       <= 1'b1;
      req_cmd         <= op;
      req_value       <= val;
      req_random_word <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      commands_sent++;
   endtask

   // random member of the shadow set, or a random value when it is empty
   function automatic logic [VALUE_W-1:0] any_member();
      if (set_size == '0) return VALUE_W'($urandom_range(0, 63));
      return set_members[VALUE_W'($urandom_range(0, int'(set_size) - 1))];
   endfunction

   // Response side: random stall, then take and check one transaction
   initial begin : reply_checker
      int            hold;
      set_reply_type want;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = rsp_no_idle ? 0 : int'($urandom_range(0, 14));
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         replies_seen++;
         if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: response with nothing outstanding (count=%0d)", $realtime,
                        rsp_count);
         end else begin
            want = replies_due.pop_front();
            if (rsp_found !== want.found || rsp_element !== want.element ||
                rsp_element_valid !== want.element_valid || rsp_count !== want.count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%t: response %0d mismatch: expected found=%0b element=%0d ",
                            "valid=%0b count=%0d, got found=%0b element=%0d valid=%0b ",
                            "count=%0d"}, $realtime, replies_seen, want.found,
                           want.element, want.element_valid, want.count, rsp_found,
                           rsp_element, rsp_element_valid, rsp_count);
            end
         end
      end
   end

   // Empty set, both ends of the value range, repeats, stale store contents
   task automatic test_edge_cases();
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;
      send_command(sse_pkg::CMD_PICK,   6'd0,  16'h0000);
      send_command(sse_pkg::CMD_PICK,   6'd17, 16'hFFFF);
      send_command(sse_pkg::CMD_LOOKUP, 6'd0,  16'h0000);
      send_command(sse_pkg::CMD_REMOVE, 6'd5,  16'h0000);
      send_command(sse_pkg::CMD_INSERT, 6'd0,  16'hFFFF);
      send_command(sse_pkg::CMD_INSERT, 6'd63, 16'h0000);
      send_command(sse_pkg::CMD_INSERT, 6'd0,  16'h1234);
      send_command(sse_pkg::CMD_LOOKUP, 6'd63, 16'h0000);
      send_command(sse_pkg::CMD_LOOKUP, 6'd1,  16'h0000);
      send_command(sse_pkg::CMD_PICK,   6'd63, 16'h0000);
      send_command(sse_pkg::CMD_PICK,   6'd0,  16'hFFFF);
      send_command(sse_pkg::CMD_PICK,   6'd0,  16'h0001);
      send_command(sse_pkg::CMD_REMOVE, 6'd1,  16'h0000);
      // removing the first member drags the last one down into slot 0
      send_command(sse_pkg::CMD_REMOVE, 6'd0,  16'hFFFF);
      send_command(sse_pkg::CMD_LOOKUP, 6'd63, 16'h0000);
      send_command(sse_pkg::CMD_LOOKUP, 6'd0,  16'h0000);
      send_command(sse_pkg::CMD_PICK,   6'd42, 16'hFFFF);
      send_command(sse_pkg::CMD_REMOVE, 6'd63, 16'h0000);
      send_command(sse_pkg::CMD_PICK,   6'd0,  16'hAAAA);
      // stale slot entries must not make old values look present
      send_command(sse_pkg::CMD_INSERT, 6'd42, 16'h5555);
      send_command(sse_pkg::CMD_LOOKUP, 6'd0,  16'h0000);
      send_command(sse_pkg::CMD_LOOKUP, 6'd63, 16'h0000);
      send_command(sse_pkg::CMD_REMOVE, 6'd42, 16'h0000);
   endtask

   // Fill the whole universe in random order, work on the full set, then
   // drain it in another random order
   task automatic test_fill_and_drain(input bit full_rate);
      int                 order[SET_SPAN];
      int                 i;
      int                 j;
      int                 tmp;
      logic [VALUE_W-1:0] val;
      req_no_idle = full_rate;
      rsp_no_idle = full_rate;
      for (i = 0; i < SET_SPAN; i++) order[i] = i;
      for (i = SET_SPAN - 1; i > 0; i--) begin
         j = int'($urandom_range(0, i));
         tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      for (i = 0; i < SET_SPAN; i++) begin
         send_command(sse_pkg::CMD_INSERT, VALUE_W'(order[i]),
                      RAND_W'($urandom_range(0, 65535)));
         if ($urandom_range(0, 3) == 0)
            send_command(sse_pkg::CMD_PICK, VALUE_W'($urandom_range(0, 63)),
                         RAND_W'($urandom_range(0, 65535)));
      end
      // full set: repeat inserts change nothing, picks reach the first and last slots
      send_command(sse_pkg::CMD_INSERT, VALUE_W'($urandom_range(0, 63)), 16'h0000);
      send_command(sse_pkg::CMD_PICK, 6'd0, 16'hFFFF);
      send_command(sse_pkg::CMD_PICK, 6'd0, 16'h0000);
      send_command(sse_pkg::CMD_PICK, 6'd0, 16'd63);
      for (i = 0; i < 6; i++)
         send_command(sse_pkg::CMD_PICK, VALUE_W'($urandom_range(0, 63)),
                      RAND_W'($urandom_range(0, 65535)));
      send_command(sse_pkg::CMD_LOOKUP, VALUE_W'($urandom_range(0, 63)), 16'h0000);
      for (i = SET_SPAN - 1; i > 0; i--) begin
         j = int'($urandom_range(0, i));
         tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      for (i = 0; i < SET_SPAN; i++) begin
         val = VALUE_W'(order[i]);
         send_command(sse_pkg::CMD_REMOVE, val, RAND_W'($urandom_range(0, 65535)));
         if ($urandom_range(0, 3) == 0)
            send_command(sse_pkg::CMD_LOOKUP, $urandom_range(0, 1) ? val : any_member(),
                         16'h0000);
         if ($urandom_range(0, 4) == 0)
            send_command(sse_pkg::CMD_PICK, val, RAND_W'($urandom_range(0, 65535)));
      end
   endtask

   // Random traffic in segments that lean towards growing or shrinking the set
   task automatic test_random_mix(input int n_items);
      int                 k;
      int                 roll;
      int                 lean;
      sse_pkg::cmd_type   op;
      logic [VALUE_W-1:0] val;
      logic [RAND_W-1:0]  word;
      lean = 50;
      for (k = 0; k < n_items; k++) begin
         if (k % 60 == 0) begin
            lean        = int'($urandom_range(15, 85));
            req_no_idle = ($urandom_range(0, 3) == 0);
            rsp_no_idle = ($urandom_range(0, 3) == 0);
         end
         roll = int'($urandom_range(0, 99));
         val  = VALUE_W'($urandom_range(0, 63));
         word = RAND_W'($urandom_range(0, 65535));
         if ($urandom_range(0, 15) == 0) word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         if (roll < 60) begin
            op = (int'($urandom_range(0, 99)) < lean) ? sse_pkg::CMD_INSERT
                                                       : sse_pkg::CMD_REMOVE;
            if (op == sse_pkg::CMD_REMOVE && $urandom_range(0, 2) != 0) val = any_member();
         end else if (roll < 80) begin
            op = sse_pkg::CMD_LOOKUP;
            if ($urandom_range(0, 1) != 0) val = any_member();
         end else begin
            op = sse_pkg::CMD_PICK;
         end
         send_command(op, val, word);
      end
   endtask

   // Drain the response side, then report
   task automatic finish_run();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("%0d requests, %0d responses checked: insert %0d, remove %0d, lookup %0d, pick %0d",
               commands_sent, replies_seen, op_tally[sse_pkg::CMD_INSERT],
               op_tally[sse_pkg::CMD_REMOVE], op_tally[sse_pkg::CMD_LOOKUP],
               op_tally[sse_pkg::CMD_PICK]);
      $display("set filled to capacity %0d times, %0d picks on an empty set, %0d mismatches",
               full_hits, empty_picks, mismatches);
      if (mismatches == 0) begin
         $display("** sparse_set_engine: PASSED **");
      end else begin
         $display("** sparse_set_engine: FAILED **");
      end
      $finish;
   endtask

   // Test sequence
   initial begin
      int i;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = sse_pkg::CMD_INSERT;
      req_value       = '0;
      req_random_word = '0;
      for (i = 0; i < SET_SPAN; i++) begin
         set_slot[i]    = '0;
         set_members[i] = '0;
      end
      set_size = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_edge_cases();
      test_fill_and_drain(1'b0);
      test_fill_and_drain(1'b1);
      test_random_mix(1240);
      finish_run();
   end

endmodule
